>>> sv/glyph_fetch_and_scale_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the glyph fetch and scale block
// Implication checks on the rising clock edge, off while in reset.
// ---------------------------------------------------------------------------
`ifndef GLYPH_FETCH_AND_SCALE_MACROS_SVH
`define GLYPH_FETCH_AND_SCALE_MACROS_SVH

// same-cycle implication
`define GFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfs port check failed");

// next-cycle implication
`define GFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfs port check failed");

`endif

>>> sv/gfs_pkg.sv
// ---------------------------------------------------------------------------
// Glyph fetch and scale package
// Bitmap geometry, code constants and the request/result types.
// ---------------------------------------------------------------------------
`default_nettype none

package gfs_pkg;

    // output bitmap size
    localparam int OUT_WIDTH  = 64;
    localparam int OUT_HEIGHT = 64;

    localparam int PIX_W      = 64;                     // pixels per output word
    localparam int WORD_SLOTS = 4;                      // word_index range
    localparam int WORDS      = (OUT_WIDTH + PIX_W - 1) / PIX_W;
    localparam int SX_K       = OUT_WIDTH / 16;         // kanji horizontal scale
    localparam int SX_A       = OUT_WIDTH / 8;          // ANK horizontal scale
    localparam int SPAN_K     = 16 * SX_K;
    localparam int SPAN_A     = 8 * SX_A;
    localparam int SY         = OUT_HEIGHT / 16;        // lines per source row

    localparam logic [7:0] SY_LINE   = 8'(SY);
    localparam logic [1:0] WORD_LAST = 2'(WORDS - 1);

    // glyph store
    localparam int STORE_DEPTH = 32;
    localparam int ADDR_W      = 5;
    localparam int PTR_W       = 6;

    // request codes
    localparam logic [1:0] FUNC_SELECT = 2'd0;
    localparam logic [1:0] FUNC_LOAD   = 2'd1;
    localparam logic [1:0] FUNC_RENDER = 2'd2;

    // character code constants
    localparam logic [15:0] CODE_BASE  = 16'h2100;
    localparam logic [13:0] ROW_STRIDE = 14'h0060;
    localparam logic [13:0] ROW_BIAS   = 14'h0020;
    localparam logic [15:0] HALF_LO    = 16'h2921;
    localparam logic [15:0] HALF_HI    = 16'h2b7e;
    localparam logic [15:0] CODE_MAX   = 16'h7c7f;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] char_code;
        logic [7:0]  glyph_byte;
        logic [3:0]  glyph_row;
    } t_in_item;

    typedef struct packed {
        logic [18:0] rom_offset;
        logic        code_invalid;
        logic [7:0]  out_line;
        logic [1:0]  word_index;
        logic [63:0] pixels;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } t_ram_req;

    typedef struct packed {
        logic [18:0] rom_offset;
        logic        invalid;
        logic        half;
    } t_select_info;

    typedef struct packed {
        logic kanji;
        logic half;
        logic blank;
    } t_expand_sel;

    typedef logic [WORD_SLOTS-1:0][PIX_W-1:0] t_line;

endpackage

`default_nettype wire

>>> sv/gfs_glyph_ram.sv
// ---------------------------------------------------------------------------
// Glyph store
// 32 x 8 single-port synchronous RAM, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module gfs_glyph_ram (
    input  wire logic              i_clk,
    input  wire gfs_pkg::t_ram_req i_req,
    output logic [7:0]             o_rdata
);
    import gfs_pkg::*;

    logic [7:0] r_mem [STORE_DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/gfs_code_decode.sv
// ---------------------------------------------------------------------------
// Code decode
// ROM record offset, invalid flag and half-width detect for a select.
// ---------------------------------------------------------------------------
`default_nettype none

module gfs_code_decode (
    input  wire logic [15:0]           i_code,
    input  wire logic                  i_kanji,
    output gfs_pkg::t_select_info      o_info
);
    import gfs_pkg::*;

    logic [15:0] w_d;
    logic [13:0] w_rec;

    assign w_d = i_code - CODE_BASE;
    // record index = 96 * row + cell - 32, only 14 bits survive the x32 wrap
    assign w_rec = 14'({6'b0, w_d[15:8]} * ROW_STRIDE) + {7'b0, w_d[6:0]} - ROW_BIAS;

    always_comb begin
        o_info.rom_offset = i_kanji ? {w_rec, 5'b0} : {i_code[14:0], 4'b0};
        o_info.invalid    = (i_code > CODE_MAX);
        o_info.half       = i_kanji && (i_code >= HALF_LO) && (i_code <= HALF_HI);
    end

endmodule

`default_nettype wire

>>> sv/gfs_row_expand.sv
// ---------------------------------------------------------------------------
// Row expander
// Builds one scaled output line from a source glyph row.
// ---------------------------------------------------------------------------
`default_nettype none

module gfs_row_expand (
    input  wire logic [7:0]           i_hi,
    input  wire logic [7:0]           i_lo,
    input  wire gfs_pkg::t_expand_sel i_sel,
    output gfs_pkg::t_line            o_line
);
    import gfs_pkg::*;

    logic [15:0]                 w_bits;
    logic [WORD_SLOTS*PIX_W-1:0] w_flat;

    function automatic logic [15:0] doubled(input logic [7:0] b);
        logic [15:0] r;
        for (int i = 0; i < 8; i++) begin
            r[2*i +: 2] = {2{b[i]}};
        end
        return r;
    endfunction

    always_comb begin
        if (i_sel.blank) begin
            w_bits = '0;
        end else if (i_sel.kanji) begin
            w_bits = i_sel.half ? doubled(i_hi) : {i_hi, i_lo};
        end else begin
            w_bits = {8'b0, i_hi};
        end
    end

    // pixel p of the line: leftmost pixel sits in the word's msb
    for (genvar p = 0; p < WORD_SLOTS * PIX_W; p++) begin : g_pix
        localparam int FlatIdx = (p / PIX_W) * PIX_W + (PIX_W - 1) - (p % PIX_W);
        if (p >= WORDS * PIX_W) begin : g_off
            assign w_flat[FlatIdx] = 1'b0;
        end else begin : g_on
            logic w_k;
            logic w_a;
            if (p < SPAN_K) begin : g_k
                assign w_k = w_bits[15 - p / SX_K];
            end else begin : g_kz
                assign w_k = 1'b0;
            end
            if (p < SPAN_A) begin : g_a
                assign w_a = w_bits[7 - p / SX_A];
            end else begin : g_az
                assign w_a = 1'b0;
            end
            assign w_flat[FlatIdx] = i_sel.kanji ? w_k : w_a;
        end
    end

    assign o_line = t_line'(w_flat);

endmodule

`default_nettype wire

>>> sv/glyph_fetch_and_scale.sv
// ---------------------------------------------------------------------------
// Glyph fetch and scale
// Character generator front end: code select, glyph load, scaled row render.
// ---------------------------------------------------------------------------
// One request at a time. A select returns its single result in the cycle
// after it is taken and a load gives no result. A render makes two reads
// of the single-port glyph RAM, expands and registers the scaled line,
// then sends one 64-bit word per cycle out of the output register, stalled
// by i_out_ready. The glyph store has no reset; rendering bytes not loaded
// since reset gives undefined pixels.
`default_nettype none

module glyph_fetch_and_scale (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire gfs_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output gfs_pkg::t_out_item     o_out
);
    import gfs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic              r_kanji, n_kanji;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic              r_half, n_half;
    logic              r_blank, n_blank;
    logic [3:0]        r_row, n_row;
    logic [7:0]        r_hi, n_hi;
    t_line             r_line, n_line;
    logic [7:0]        r_line_no, n_line_no;
    logic [7:0]        r_last_line, n_last_line;
    logic [1:0]        r_word, n_word;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_ram_req          w_ram_req;
    logic [7:0]        w_rdata;
    t_select_info      w_info;
    t_expand_sel       w_sel;
    t_line             w_line;
    logic              w_slot_free;
    logic              w_accept;
    logic              w_last;
    logic [7:0]        w_first_line;

    gfs_glyph_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    gfs_code_decode u_decode (
        .i_code  (i_in.char_code),
        .i_kanji (r_kanji),
        .o_info  (w_info)
    );

    assign w_sel = '{kanji: r_kanji, half: r_half, blank: r_blank};

    gfs_row_expand u_expand (
        .i_hi   (r_hi),
        .i_lo   (w_rdata),
        .i_sel  (w_sel),
        .o_line (w_line)
    );

    assign w_slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE) && w_slot_free;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_last       = (r_line_no == r_last_line) && (r_word == WORD_LAST);
    assign w_first_line = 8'({4'b0, i_in.glyph_row} * SY_LINE);

    always_comb begin
        n_state     = r_state;
        n_kanji     = i_cfg_we ? i_cfg_wdata : r_kanji;
        n_ptr       = r_ptr;
        n_half      = r_half;
        n_blank     = r_blank;
        n_row       = r_row;
        n_hi        = r_hi;
        n_line      = r_line;
        n_line_no   = r_line_no;
        n_last_line = r_last_line;
        n_word      = r_word;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        w_ram_req.we    = 1'b0;
        w_ram_req.addr  = r_ptr[ADDR_W-1:0];
        w_ram_req.wdata = i_in.glyph_byte;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.func)
                        FUNC_SELECT: begin
                            n_ptr       = '0;
                            n_blank     = w_info.invalid;
                            n_half      = w_info.half;
                            n_out_valid = 1'b1;
                            n_out       = '{rom_offset: w_info.rom_offset,
                                            code_invalid: w_info.invalid,
                                            out_line: 8'd0, word_index: 2'd0,
                                            pixels: 64'd0, last: 1'b1};
                        end
                        FUNC_LOAD: begin
                            // extra bytes past the record are dropped
                            if (r_ptr < PTR_W'(STORE_DEPTH)) begin
                                w_ram_req.we = 1'b1;
                                n_ptr        = r_ptr + 1'b1;
                            end
                        end
                        FUNC_RENDER: begin
                            // full-width kanji rows are two bytes
                            w_ram_req.addr = (r_kanji && !r_half) ?
                                             {i_in.glyph_row, 1'b0} :
                                             {1'b0, i_in.glyph_row};
                            n_row       = i_in.glyph_row;
                            n_line_no   = w_first_line;
                            n_last_line = w_first_line + SY_LINE - 8'd1;
                            n_word      = 2'd0;
                            n_state     = S_RD0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD0: begin
                n_hi           = w_rdata;
                w_ram_req.addr = {r_row, 1'b1};
                n_state        = S_RD1;
            end
            S_RD1: begin
                n_line  = w_line;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{rom_offset: 19'd0, code_invalid: r_blank,
                                    out_line: r_line_no, word_index: r_word,
                                    pixels: r_line[r_word], last: w_last};
                    if (r_word == WORD_LAST) begin
                        n_word    = 2'd0;
                        n_line_no = r_line_no + 8'd1;
                    end else begin
                        n_word = r_word + 2'd1;
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_hi        <= n_hi;
        r_line      <= n_line;
        r_line_no   <= n_line_no;
        r_last_line <= n_last_line;
        r_word      <= n_word;
        r_out       <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kanji     <= 1'b1;
            r_ptr       <= '0;
            r_half      <= 1'b0;
            r_blank     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kanji     <= n_kanji;
            r_ptr       <= n_ptr;
            r_half      <= n_half;
            r_blank     <= n_blank;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> sv/gfs_checker.sv
// ---------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the glyph fetch and scale block.
// ---------------------------------------------------------------------------
`default_nettype none

`include "glyph_fetch_and_scale_macros.svh"

module gfs_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_ready,
    input wire gfs_pkg::t_in_item i_in,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire gfs_pkg::t_out_item o_out
);
    import gfs_pkg::*;

    // a stalled result holds
    `GFS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out))

    // no new request while a render still has words to send
    `GFS_ASSERT_NOW(a_busy_render, i_clk, i_rst_n, o_out_valid && !o_out.last, !o_in_ready)

    // a select answers with one final, pixel-free result in the next cycle
    `GFS_ASSERT_NEXT(a_select_result, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in.func == FUNC_SELECT, o_out_valid && o_out.last && o_out.pixels == 64'd0 && o_out.out_line == 8'd0)

    // only select results carry an offset
    `GFS_ASSERT_NOW(a_offset_only_select, i_clk, i_rst_n, o_out_valid && o_out.rom_offset != 19'd0, o_out.last && o_out.word_index == 2'd0 && o_out.pixels == 64'd0)

endmodule

bind glyph_fetch_and_scale gfs_checker u_gfs_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// Glyph fetch and scale testbench
// Drives select, load and render requests through the valid/ready input with
// random gaps, predicts every result word in-line and checks each word
// arriving at the output, under random back-pressure, in kanji and ANK modes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gfs_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;   // unused code, no result
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         SETTLE      = 12;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      i_out_ready = 1'b0;
    t_in_item  i_in        = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    glyph_fetch_and_scale dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    t_in_item  req_queue[$];     // requests waiting for the driver
    t_out_item due_words[$];     // predicted result words, oldest first
    bit        req_fire   = 1'b0;
    bit        steady     = 1'b0;
    int        mismatches = 0;
    int        cycle_cnt  = 0;
    t_out_item want_word;

    // shadow of the block state
    logic       mode_kanji = 1'b1;
    logic [7:0] glyph_mem[STORE_DEPTH];
    logic [5:0] load_ptr   = '0;
    logic       half_flag  = 1'b0;
    logic       blank_flag = 1'b1;

    task automatic predict_request(input t_in_item r);
        t_out_item   o;
        logic [15:0] d;
        logic [31:0] off;
        logic [15:0] bits;
        logic [7:0]  b;
        t_line       line;
        int          w, sx, span, src;
        o    = '0;
        line = '0;
        bits = '0;
        case (r.func)
            FUNC_SELECT: begin
                if (mode_kanji) begin
                    d   = r.char_code - CODE_BASE;
                    off = 32'd32 * (32'(ROW_STRIDE) * 32'(d[15:8]) + 32'(d[6:0])
                          - 32'(ROW_BIAS));
                end else begin
                    off = 32'd16 * 32'(r.char_code);
                end
                o.rom_offset   = off[18:0];
                o.code_invalid = r.char_code > CODE_MAX;
                o.last         = 1'b1;
                load_ptr   = '0;
                blank_flag = o.code_invalid;
                half_flag  = mode_kanji && r.char_code >= HALF_LO && r.char_code <= HALF_HI;
                due_words.push_back(o);
            end
            FUNC_LOAD: begin
                // pointer saturates at the store depth, extra bytes dropped
                if (load_ptr < STORE_DEPTH) begin
                    glyph_mem[load_ptr[4:0]] = r.glyph_byte;
                    load_ptr = load_ptr + 6'd1;
                end
            end
            FUNC_RENDER: begin
                w = mode_kanji ? 16 : 8;
                if (mode_kanji && half_flag) begin
                    b = glyph_mem[{1'b0, r.glyph_row}];
                    for (int i = 0; i < 8; i++)
                        bits[2*i +: 2] = {2{b[i]}};
                end else if (mode_kanji) begin
                    bits = {glyph_mem[{r.glyph_row, 1'b0}], glyph_mem[{r.glyph_row, 1'b1}]};
                end else begin
                    bits = {8'h00, glyph_mem[{1'b0, r.glyph_row}]};
                end
                if (blank_flag)
                    bits = '0;
                sx   = OUT_WIDTH / w;
                span = w * sx;
                for (int p = 0; p < span && p < WORDS * PIX_W; p++) begin
                    src = p / sx;
                    if (bits[w - 1 - src])
                        line[p / PIX_W][PIX_W - 1 - (p % PIX_W)] = 1'b1;
                end
                for (int l = 0; l < SY; l++) begin
                    for (int k = 0; k < WORDS; k++) begin
                        o              = '0;
                        o.code_invalid = blank_flag;
                        o.out_line     = 8'(int'(r.glyph_row) * SY + l);
                        o.word_index   = 2'(k);
                        o.pixels       = line[k];
                        o.last         = (l == SY - 1) && (k == WORDS - 1);
                        due_words.push_back(o);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic flag_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
    endtask

    // request acceptance, register writes and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                mode_kanji = i_cfg_wdata;
            if (i_in_valid && o_in_ready) begin
                predict_request(i_in);
                req_fire = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, o_out);
                    mismatches++;
                end else begin
                    want_word = due_words.pop_front();
                    if (o_out.rom_offset !== want_word.rom_offset)
                        flag_field("rom_offset", want_word.rom_offset, o_out.rom_offset);
                    if (o_out.code_invalid !== want_word.code_invalid)
                        flag_field("code_invalid", want_word.code_invalid, o_out.code_invalid);
                    if (o_out.out_line !== want_word.out_line)
                        flag_field("out_line", want_word.out_line, o_out.out_line);
                    if (o_out.word_index !== want_word.word_index)
                        flag_field("word_index", want_word.word_index, o_out.word_index);
                    if (o_out.pixels !== want_word.pixels)
                        flag_field("pixels", want_word.pixels, o_out.pixels);
                    if (o_out.last !== want_word.last)
                        flag_field("last", want_word.last, o_out.last);
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || req_fire)) begin
            if (req_queue.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
                i_in       <= req_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        req_fire = 1'b0;
    end

    always @(negedge i_clk)
        i_out_ready <= steady || ($urandom_range(99) >= 34);

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // v is the code, byte or row depending on the request type
    task automatic send(input logic [1:0] f, input logic [15:0] v);
        t_in_item r;
        r.func       = f;
        r.char_code  = 16'($urandom);
        r.glyph_byte = 8'($urandom);
        r.glyph_row  = 4'($urandom);
        case (f)
            FUNC_SELECT: r.char_code  = v;
            FUNC_LOAD:   r.glyph_byte = v[7:0];
            FUNC_RENDER: r.glyph_row  = v[3:0];
            default: ;
        endcase
        req_queue.push_back(r);
    endtask

    function automatic logic [15:0] pick_code(input bit kanji);
        int n;
        n = $urandom_range(99);
        if (kanji) begin
            if (n < 35)
                return {8'($urandom_range(8'h7c, 8'h21)), 8'($urandom_range(8'h7e, 8'h21))};
            if (n < 50)
                return 16'($urandom_range(HALF_HI, HALF_LO));
            if (n < 65)
                return 16'($urandom_range(16'hffff, CODE_MAX + 16'd1));
        end else begin
            if (n < 60)
                return 16'($urandom_range(255));
            if (n < 75)
                return 16'($urandom_range(16'hffff, CODE_MAX + 16'd1));
        end
        return 16'($urandom);
    endfunction

    task automatic drain_all();
        while (req_queue.size() != 0 || i_in_valid || due_words.size() != 0)
            @(posedge i_clk);
        // a trailing load leaves no result to wait on
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic kanji);
        drain_all();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= kanji;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly select / load run / renders, the rest loose requests
    task automatic run_random(input int n_items, input bit kanji);
        int cnt, nl, n;
        logic [1:0] f;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(99) < 85) begin
                send(FUNC_SELECT, pick_code(kanji));
                n  = $urandom_range(99);
                nl = (n < 35) ? 32 : (n < 85) ? $urandom_range(4) : $urandom_range(36, 33);
                repeat (nl) send(FUNC_LOAD, 16'($urandom_range(255)));
                n = $urandom_range(6, 2);
                repeat (n) send(FUNC_RENDER, 16'($urandom_range(15)));
                cnt += 1 + nl + n;
            end else begin
                f = 2'($urandom_range(3));
                send(f, (f == FUNC_SELECT) ? pick_code(kanji) : 16'($urandom));
                if (f != FUNC_NONE)
                    cnt++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b1);
        // fill the whole store first so no render ever reads an unwritten byte
        send(FUNC_SELECT, 16'h3021);
        for (int i = 0; i < STORE_DEPTH; i++)
            send(FUNC_LOAD, (i == 0) ? 16'hff : (i == 1) ? 16'h00 :
                 (i == 2) ? 16'h80 : (i == 3) ? 16'h01 : 16'($urandom_range(255)));
        send(FUNC_LOAD, 16'h5a);                 // past the end, dropped
        send(FUNC_RENDER, 16'd0);
        send(FUNC_RENDER, 16'd15);
        send(FUNC_SELECT, HALF_LO);              // half-width, doubled pixels
        send(FUNC_RENDER, 16'd0);
        send(FUNC_RENDER, 16'd15);
        send(FUNC_SELECT, HALF_HI);
        send(FUNC_RENDER, 16'd3);
        send(FUNC_SELECT, HALF_LO - 16'd1);
        send(FUNC_SELECT, HALF_HI + 16'd1);
        send(FUNC_RENDER, 16'd7);
        send(FUNC_SELECT, CODE_MAX);
        send(FUNC_RENDER, 16'd2);
        send(FUNC_SELECT, CODE_MAX + 16'd1);     // invalid, blank render
        send(FUNC_RENDER, 16'd5);
        send(FUNC_SELECT, 16'hffff);
        send(FUNC_SELECT, 16'h0000);             // offset wraps
        send(FUNC_NONE, 16'h0000);
        send(FUNC_RENDER, 16'd9);

        write_mode(1'b0);
        send(FUNC_SELECT, 16'hffff);
        send(FUNC_RENDER, 16'd15);
        send(FUNC_SELECT, 16'h0041);
        send(FUNC_RENDER, 16'd0);
        send(FUNC_SELECT, 16'h00ff);
        send(FUNC_RENDER, 16'd8);
        run_random(15, 1'b0);

        write_mode(1'b1);
        steady = 1'b1;
        run_random(15, 1'b1);
        drain_all();
        steady = 1'b0;

        write_mode(1'b0);
        run_random(15, 1'b0);
        write_mode(1'b1);
        run_random(15, 1'b1);
        drain_all();

        if (mismatches == 0 && due_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> glyph_fetch_and_scale.f
+incdir+sv
sv/gfs_pkg.sv
sv/gfs_glyph_ram.sv
sv/gfs_code_decode.sv
sv/gfs_row_expand.sv
sv/glyph_fetch_and_scale.sv
sv/gfs_checker.sv
dv/tb_top.sv
